// File: rtl/bwfpa_pkg.sv
// ----------------------------------------------------------------------------
// bwfpa_pkg
// shared codes and field widths of the best/worst fit page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bwfpa_pkg;

    // request kinds carried on the slave tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_KILL = 1'b1;

    // placement policy
    localparam logic FIT_BEST  = 1'b0;
    localparam logic FIT_WORST = 1'b1;

    // result status codes
    localparam int W_STATUS = 3;
    localparam logic [W_STATUS-1:0] ST_OK       = 3'd0;
    localparam logic [W_STATUS-1:0] ST_PRESENT  = 3'd1;
    localparam logic [W_STATUS-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [W_STATUS-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [W_STATUS-1:0] ST_ZERO     = 3'd4;

    // field widths
    localparam int W_ID    = 8;
    localparam int W_KB    = 8;
    localparam int W_PAGES = 6;
    localparam int W_START = 5;
    localparam int W_FRAG  = 5;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

endpackage

`default_nettype wire

// File: rtl/bwfpa_owner_ram.sv
// ----------------------------------------------------------------------------
// bwfpa_owner_ram
// page owner store, one write port and one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module bwfpa_owner_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 8,
    parameter int AW    = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/best_worst_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// best_worst_fit_page_allocator
// contiguous page allocator with best-fit / worst-fit placement
// ----------------------------------------------------------------------------
// a zero-size add goes from accept straight to the done state; other requests
// scan every page, drain, decide and, on a successful add, write its pages
// throughput: one request in flight; the next is accepted the cycle after the
// result register loads; the owner ram scan at one page a cycle sets the rate
// reset (synchronous, active low): all pages free, one free fragment, best fit
// owner ram holds no reset; entries are read only behind a set used bit
`default_nettype none

module best_worst_fit_page_allocator #(
    parameter int PAGES   = 32,
    parameter int PAGE_KB = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config channel: fit mode bit
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic                             i_cfg_data,
    // request stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: [7:0] prog_id, [15:8] size_kb
    input  wire logic [bwfpa_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: [0] cmd
    input  wire logic                             i_s_axis_tuser,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // tdata: [2:0] status, [8:3] pages, [13:9] start_page,
    //        [18:14] free_fragments, [23:19] zero
    output logic [bwfpa_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    import bwfpa_pkg::*;

    // widths that follow from the map size
    localparam int AW  = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW  = $clog2(PAGES + 1);
    localparam int EW  = CW + 1;
    localparam int FW  = $clog2(PAGES / 2 + 2);
    localparam int KW  = $clog2(PAGES * PAGE_KB + 1);
    localparam int AKW = $clog2((1 << W_KB) - 1 + PAGE_KB + 1);
    localparam int SW  = (KW > AKW) ? KW : AKW;

    localparam logic [AW-1:0] LAST_IDX = AW'(PAGES - 1);
    localparam logic [SW-1:0] PKB      = SW'(PAGE_KB);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DRAIN  = 6'b000100,
        S_DECIDE = 6'b001000,
        S_WRITE  = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // request
    logic            r_cmd;
    logic [W_ID-1:0] r_id;
    logic [W_KB-1:0] r_kb;
    logic            r_mode;

    // map: used bit per page in flops, owner in ram
    logic [PAGES-1:0] r_used;
    logic [FW-1:0]    r_frag;

    // scan pipeline
    logic [AW-1:0] r_addr;
    logic          r_rvld;
    logic [AW-1:0] r_ridx;
    logic [W_ID-1:0] ram_rdata;

    // free run tracker
    logic [CW-1:0] r_run_len;
    logic [AW-1:0] r_run_start;
    logic [SW-1:0] r_run_kb;
    logic          r_found;
    logic [CW-1:0] r_best_len;
    logic [AW-1:0] r_best_start;

    // owner tracker
    logic          r_present;
    logic          r_contig;
    logic [AW-1:0] r_first;
    logic [CW-1:0] r_kcnt;

    // allocation write pass
    logic [AW-1:0] r_wptr;
    logic [SW-1:0] r_acc;
    logic [CW-1:0] r_wcnt;

    // result
    logic [W_STATUS-1:0] r_status;
    logic [CW-1:0]       r_pages;
    logic [AW-1:0]       r_start;
    logic                r_ovld;
    logic [OUT_TDATA_W-1:0] r_odata;

    logic in_beat;
    logic out_free;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_ovld || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = r_odata;

    // owner store
    bwfpa_owner_ram #(
        .DEPTH (PAGES),
        .WIDTH (W_ID),
        .AW    (AW)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WRITE),
        .i_waddr (r_wptr),
        .i_wdata (r_id),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ---- scan step on the page whose owner just came back from the ram ----
    logic          pg_free;
    logic          own_match;
    logic          cand_end;
    logic [CW-1:0] cand_len;
    logic [AW-1:0] cand_start;
    logic [SW-1:0] cand_kb;
    logic          cand_take;

    always_comb begin
        pg_free    = !r_used[r_ridx];
        own_match  = r_used[r_ridx] && (ram_rdata == r_id);
        // a run closes on a used page after free ones, or at the map end
        cand_end   = (pg_free && (r_ridx == LAST_IDX)) || (!pg_free && (r_run_len != '0));
        cand_len   = pg_free ? r_run_len + CW'(1) : r_run_len;
        cand_start = (pg_free && (r_run_len == '0)) ? r_ridx : r_run_start;
        cand_kb    = pg_free ? r_run_kb + PKB : r_run_kb;
        // ties keep the earlier run, so only strict improvement replaces
        cand_take  = cand_end && (cand_kb >= SW'(r_kb)) &&
                     (!r_found ||
                      ((r_mode == FIT_BEST)  && (cand_len < r_best_len)) ||
                      ((r_mode == FIT_WORST) && (cand_len > r_best_len)));
    end

    // ---- kill: freed range, neighbours and fragment update ----
    logic [EW-1:0]    kill_end;
    logic [PAGES-1:0] kill_mask;
    logic             left_free;
    logic             right_free;
    logic [FW-1:0]    kill_frag;

    always_comb begin
        kill_end = EW'(r_first) + EW'(r_kcnt);
        for (int p = 0; p < PAGES; p++) begin
            kill_mask[p] = (EW'(p) >= EW'(r_first)) && (EW'(p) < kill_end);
        end
        left_free  = (r_first != '0) && !r_used[r_first - AW'(1)];
        right_free = (kill_end < EW'(PAGES)) && !r_used[kill_end[AW-1:0]];
        // the freed run is new, and merges with each free neighbour
        kill_frag  = r_frag + FW'(1) - FW'(left_free) - FW'(right_free);
    end

    // ---- allocation write step ----
    logic [SW-1:0] acc_nx;
    logic [CW-1:0] wcnt_nx;
    logic          wr_last;

    always_comb begin
        acc_nx  = r_acc + PKB;
        wcnt_nx = r_wcnt + CW'(1);
        wr_last = (acc_nx >= SW'(r_kb));
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if ((i_s_axis_tuser == CMD_ADD) && (i_s_axis_tdata[15:8] == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_addr == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if ((r_cmd == CMD_ADD) && !r_present && r_found) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE: begin
                if (wr_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= FIT_BEST;
            r_used  <= '0;
            r_frag  <= FW'(1);
            r_rvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r_rvld <= (r_state == S_SCAN);

            if ((r_state == S_DECIDE) && (r_cmd == CMD_KILL) && r_present) begin
                r_used <= r_used & ~kill_mask;
                r_frag <= kill_frag;
            end
            if (r_state == S_WRITE) begin
                r_used[r_wptr] <= 1'b1;
                // a run used up entirely disappears from the free list
                if (wr_last && (wcnt_nx == r_best_len)) begin
                    r_frag <= r_frag - FW'(1);
                end
            end

            if ((r_state == S_DONE) && out_free) begin
                r_ovld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // ---- datapath ----
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    r_cmd       <= i_s_axis_tuser;
                    r_id        <= i_s_axis_tdata[7:0];
                    r_kb        <= i_s_axis_tdata[15:8];
                    r_addr      <= '0;
                    r_run_len   <= '0;
                    r_run_start <= '0;
                    r_run_kb    <= '0;
                    r_found     <= 1'b0;
                    r_best_len  <= '0;
                    r_best_start <= '0;
                    r_present   <= 1'b0;
                    r_contig    <= 1'b0;
                    r_first     <= '0;
                    r_kcnt      <= '0;
                    r_status    <= ST_ZERO;
                    r_pages     <= '0;
                    r_start     <= '0;
                end
            end
            S_SCAN: begin
                r_addr <= r_addr + AW'(1);
            end
            S_DECIDE: begin
                if (r_cmd == CMD_ADD) begin
                    if (r_present) begin
                        r_status <= ST_PRESENT;
                    end else if (!r_found) begin
                        r_status <= ST_NOSPACE;
                    end else begin
                        r_status <= ST_OK;
                        r_start  <= r_best_start;
                        r_wptr   <= r_best_start;
                        r_acc    <= '0;
                        r_wcnt   <= '0;
                    end
                end else begin
                    if (!r_present) begin
                        r_status <= ST_NOTFOUND;
                    end else begin
                        r_status <= ST_OK;
                        r_pages  <= r_kcnt;
                        r_start  <= r_first;
                    end
                end
            end
            S_WRITE: begin
                r_wptr <= r_wptr + AW'(1);
                r_acc  <= acc_nx;
                r_wcnt <= wcnt_nx;
                if (wr_last) begin
                    r_pages <= wcnt_nx;
                end
            end
            default: begin
            end
        endcase

        // scan results land in the cycle after their ram address
        if (r_rvld) begin
            if (pg_free) begin
                r_run_len   <= cand_len;
                r_run_start <= cand_start;
                r_run_kb    <= cand_kb;
            end else begin
                r_run_len <= '0;
                r_run_kb  <= '0;
            end
            if (cand_take) begin
                r_found      <= 1'b1;
                r_best_len   <= cand_len;
                r_best_start <= cand_start;
            end
            // owner pages form one contiguous run from the first match
            if (own_match && !r_present) begin
                r_present <= 1'b1;
                r_contig  <= 1'b1;
                r_first   <= r_ridx;
                r_kcnt    <= CW'(1);
            end else if (r_present && r_contig) begin
                if (own_match) begin
                    r_kcnt <= r_kcnt + CW'(1);
                end else begin
                    r_contig <= 1'b0;
                end
            end
        end
        r_ridx <= r_addr;

        // output register, loaded as the request retires
        if ((r_state == S_DONE) && out_free) begin
            r_odata <= {(OUT_TDATA_W - W_STATUS - W_PAGES - W_START - W_FRAG)'(0),
                        W_FRAG'(r_frag),
                        W_START'(r_start),
                        W_PAGES'(r_pages),
                        r_status};
        end
    end

    // ---- assertions ----
    // an allocation only ever writes pages that were free
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> !r_used[r_wptr])
        else $error("allocation writes a used page");

    // no free fragment exactly when every page is used
    a_frag_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frag == '0) == (&r_used))
        else $error("fragment count out of step with page map");

    // ram read data is only consumed inside the scan
    a_rvld_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvld |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("scan data outside scan window");

    // a successful kill always reclaims at least one page
    a_kill_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DECIDE) && (r_cmd == CMD_KILL) && r_present) |=> (r_pages != '0))
        else $error("kill reclaimed no page");

endmodule

`default_nettype wire

// File: tb/sv/best_worst_fit_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_worst_fit_page_allocator_tb
// self-checking bench for the contiguous page allocator: directed corner
// requests under both fit policies, then random add/kill traffic with a
// shadow page map predicting every result beat, random idling on both streams
// ----------------------------------------------------------------------------

module best_worst_fit_page_allocator_tb;

    import bwfpa_pkg::*;

    localparam int PAGES        = 32;
    localparam int PAGE_KB      = 4;
    localparam int POOL_SIZE    = 16;
    localparam int DRAIN_CYCLES = 2 * PAGES + 8;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int REPORT_MAX   = 10;

    // one predicted result beat
    typedef struct {
        logic [W_STATUS-1:0] status;
        logic [W_PAGES-1:0]  pages;
        logic [W_START-1:0]  start_pg;
        logic [W_FRAG-1:0]   frags;
    } t_alloc_result;

    // ------------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data      = FIT_BEST;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // [7:0] prog_id, [15:8] size_kb
    logic                   i_s_axis_tuser  = CMD_ADD;  // [0] cmd
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [2:0] status, [8:3] pages, [13:9] start_page, [18:14] free_fragments,
    // [23:19] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    best_worst_fit_page_allocator #(
        .PAGES   (PAGES),
        .PAGE_KB (PAGE_KB)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // shadow page map and placement policy
    // ------------------------------------------------------------------------
    bit               page_taken  [PAGES];
    logic [W_ID-1:0]  page_holder [PAGES];
    logic             fit_policy;

    t_alloc_result    pending_results[$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    bit               no_idle        = 1'b0;   // stretch with both sides streaming
    logic [W_ID-1:0]  id_pool [POOL_SIZE];

    // mirror of one request: updates the shadow map, returns the result beat
    task automatic predict_request(input logic cmd, input logic [W_ID-1:0] id,
                                   input logic [W_KB-1:0] kb,
                                   output t_alloc_result res);
        int  need;
        int  first_pg;
        int  i;
        int  run_s;
        int  run_len;
        int  pick_s;
        int  pick_len;
        int  n_pages;
        int  n_frags;
        bit  owned;
        bit  found;
        logic [W_STATUS-1:0] st;

        need     = (int'(kb) + PAGE_KB - 1) / PAGE_KB;
        owned    = 1'b0;
        first_pg = 0;
        found    = 1'b0;
        pick_s   = 0;
        pick_len = 0;
        n_pages  = 0;
        st       = ST_OK;
        for (i = 0; i < PAGES; i++) begin
            if (!owned && page_taken[i] && page_holder[i] == id) begin
                owned    = 1'b1;
                first_pg = i;
            end
        end

        if (cmd == CMD_ADD) begin
            // zero size is refused before the presence check
            if (kb == 0) begin
                st = ST_ZERO;
            end else if (owned) begin
                st = ST_PRESENT;
            end else begin
                i = 0;
                while (i < PAGES) begin
                    if (page_taken[i]) begin
                        i++;
                    end else begin
                        run_s   = i;
                        run_len = 0;
                        while (i < PAGES && !page_taken[i]) begin
                            run_len++;
                            i++;
                        end
                        // strict compares keep ties at the lowest address
                        if (run_len >= need &&
                            (!found ||
                             (fit_policy == FIT_BEST  && run_len < pick_len) ||
                             (fit_policy == FIT_WORST && run_len > pick_len))) begin
                            found    = 1'b1;
                            pick_s   = run_s;
                            pick_len = run_len;
                        end
                    end
                end
                if (!found) begin
                    st     = ST_NOSPACE;
                    pick_s = 0;
                end else begin
                    for (i = pick_s; i < pick_s + need && i < PAGES; i++) begin
                        page_taken[i]  = 1'b1;
                        page_holder[i] = id;
                    end
                    n_pages = need;
                end
            end
        end else begin
            if (!owned) begin
                st = ST_NOTFOUND;
            end else begin
                i = first_pg;
                while (i < PAGES && page_taken[i] && page_holder[i] == id) begin
                    page_taken[i]  = 1'b0;
                    page_holder[i] = '0;
                    n_pages++;
                    i++;
                end
                pick_s = first_pg;
            end
        end

        n_frags = 0;
        for (i = 0; i < PAGES; i++) begin
            if (!page_taken[i] && (i == 0 || page_taken[i-1])) n_frags++;
        end

        res.status   = st;
        res.pages    = W_PAGES'(n_pages);
        res.start_pg = W_START'(pick_s);
        res.frags    = W_FRAG'(n_frags);
    endtask

    // ------------------------------------------------------------------------
    // idle lengths: mostly short, a few long
    // ------------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 2);
        if (r < 90) return $urandom_range(3, 8);
        if (r < 98) return $urandom_range(9, 20);
        return $urandom_range(30, 60);
    endfunction

    function automatic int send_gap();
        if (no_idle || $urandom_range(0, 99) < 65) return 0;
        return idle_len();
    endfunction

    // ------------------------------------------------------------------------
    // request side: one beat per call, valid stays up across back-to-back beats
    // ------------------------------------------------------------------------
    task automatic send_request(input logic cmd, input logic [W_ID-1:0] id,
                                input logic [W_KB-1:0] kb);
        int            gap;
        t_alloc_result res;
        gap = send_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {kb, id};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        // beat accepted at this edge
        predict_request(cmd, id, kb, res);
        pending_results.push_back(res);
    endtask

    // drop valid and wait for every result beat plus a latency margin
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // fit mode write, only with the allocator idle
    task automatic set_fit_policy(input logic mode);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        fit_policy = mode;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls on tready
    // ------------------------------------------------------------------------
    int ready_hold = 0;
    always @(negedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
        end else if (no_idle) begin
            i_m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_m_axis_tready <= 1'b0;
            ready_hold = idle_len();
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("%0t: %s", $realtime, msg);
    endtask

    // each result beat against the oldest prediction
    always @(posedge i_clk) begin : check_beat
        t_alloc_result       want;
        logic [W_STATUS-1:0] got_status;
        logic [W_PAGES-1:0]  got_pages;
        logic [W_START-1:0]  got_start;
        logic [W_FRAG-1:0]   got_frags;
        logic [4:0]          got_pad;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            {got_pad, got_frags, got_start, got_pages, got_status} = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result beat with none expected: tdata %h",
                                        o_m_axis_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got_status !== want.status || got_pages !== want.pages ||
                    got_start !== want.start_pg || got_frags !== want.frags ||
                    got_pad !== 5'd0) begin
                    flag_mismatch($sformatf(
                        {"result mismatch: status %0d/%0d pages %0d/%0d ",
                         "start %0d/%0d frags %0d/%0d pad %0h (expected/actual)"},
                        want.status, got_status, want.pages, got_pages,
                        want.start_pg, got_start, want.frags, got_frags, got_pad));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // zero size, kill of an id never added, a size beyond the whole map
    task automatic test_reset_corners();
        set_fit_policy(FIT_BEST);
        send_request(CMD_ADD,  8'd0,   8'd0);
        send_request(CMD_KILL, 8'd0,   8'd0);
        send_request(CMD_ADD,  8'd255, 8'd255);
    endtask

    // full map, duplicate id, then a hole that best fit must choose
    task automatic test_best_fit_placement();
        send_request(CMD_ADD,  8'd1,  8'd128);   // exactly all pages
        send_request(CMD_ADD,  8'd2,  8'd1);     // map full
        send_request(CMD_ADD,  8'd1,  8'd4);     // id already present
        send_request(CMD_KILL, 8'd1,  8'd0);
        send_request(CMD_ADD,  8'd10, 8'd8);
        send_request(CMD_ADD,  8'd11, 8'd4);
        send_request(CMD_ADD,  8'd12, 8'd16);
        send_request(CMD_ADD,  8'd13, 8'd3);     // rounds up to one page
        send_request(CMD_KILL, 8'd11, 8'd0);     // one-page hole
        send_request(CMD_ADD,  8'd14, 8'd4);     // best fit takes the hole
    endtask

    // worst fit takes the big tail run, then everything is freed
    task automatic test_worst_fit_placement();
        set_fit_policy(FIT_WORST);
        send_request(CMD_KILL, 8'd12,  8'd0);
        send_request(CMD_ADD,  8'd15,  8'd4);
        send_request(CMD_ADD,  8'd10,  8'd4);
        send_request(CMD_ADD,  8'd16,  8'd255);
        send_request(CMD_KILL, 8'd15,  8'd0);
        send_request(CMD_KILL, 8'd10,  8'd0);
        send_request(CMD_KILL, 8'd14,  8'd0);
        send_request(CMD_KILL, 8'd13,  8'd0);
        send_request(CMD_KILL, 8'd16,  8'd0);
    endtask

    // mostly adds and kills on a small id pool so the map fills and fragments
    task automatic test_random_traffic(input logic mode, input int count);
        int              n;
        int              r;
        int              s;
        logic            cmd;
        logic [W_ID-1:0] id;
        logic [W_KB-1:0] kb;
        set_fit_policy(mode);
        for (n = 0; n < POOL_SIZE; n++) id_pool[n] = W_ID'($urandom_range(0, 255));
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
            r = $urandom_range(0, 99);
            s = $urandom_range(0, 99);
            if (s < 4)       kb = 8'd0;
            else if (s < 70) kb = W_KB'($urandom_range(1, 24));
            else if (s < 85) kb = W_KB'($urandom_range(25, 64));
            else             kb = W_KB'($urandom_range(65, 255));
            if (r < 5) begin
                // noise: any id, any command
                cmd = 1'($urandom_range(0, 1));
                id  = W_ID'($urandom_range(0, 255));
                kb  = W_KB'($urandom_range(0, 255));
            end else begin
                cmd = (r < 55) ? CMD_ADD : CMD_KILL;
                id  = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            send_request(cmd, id, kb);
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < PAGES; i++) begin
            page_taken[i]  = 1'b0;
            page_holder[i] = '0;
        end
        fit_policy = FIT_BEST;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_corners();
        test_best_fit_placement();
        test_worst_fit_placement();
        test_random_traffic(FIT_WORST, 200);
        test_random_traffic(FIT_BEST,  200);
        test_random_traffic(FIT_WORST, 200);
        test_random_traffic(FIT_BEST,  200);

        wait_idle();
        if (mismatch_count == 0) begin
            $display("best_worst_fit_page_allocator_tb passed");
        end else begin
            $display("best_worst_fit_page_allocator_tb failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("best_worst_fit_page_allocator_tb failed");
        $finish;
    end

endmodule
